/* src/kfm_pkg.sv */
// shared types and constants for the kmp first match finder
`default_nettype none

package kfm_pkg;

   // payload widths
   localparam int BYTE_W = 8;
   localparam int POS_W  = 16;

   // command codes
   localparam logic CMD_PATTERN = 1'b0;
   localparam logic CMD_TEXT    = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

`default_nettype wire

/* src/kfm_if.sv */
// handshake channels for request and response items
`default_nettype none

interface kfm_req_if;
   import kfm_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [BYTE_W-1:0] byte_value;
   logic              last_flag;

   modport source (output valid, command, byte_value, last_flag, input ready);
   modport sink   (input valid, command, byte_value, last_flag, output ready);
endinterface

interface kfm_rsp_if;
   import kfm_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] match_position;

   modport source (output valid, found, match_position, input ready);
   modport sink   (input valid, found, match_position, output ready);
endinterface

`default_nettype wire

/* src/kmp_first_match_finder_unit.sv */
// kmp first match finder: online failure table build and first match search
//
// Pattern bytes (command 0) are stored and their failure links built as they
// arrive; any pattern byte restarts the search. Text bytes (command 1) are then
// searched; at the first full match one item with found=1 and the start index is
// sent, else one item with found=0 after the text byte carrying last_flag. An
// empty pattern matches at position 0. One shared compare step reads the
// pattern and failure memories at one address per cycle. A byte needs either no
// compare step or one plus one per failure-link fallback, and no new byte is
// accepted until it is done. A byte that produces a result then loads the
// output register, which stalls while an earlier result waits.
`default_nettype none

module kmp_first_match_finder_unit #(
   parameter int PATTERN_MAX = 128,
   parameter int TEXT_MAX    = 65536
) (
   input  wire        clock,
   input  wire        reset,
   kfm_req_if.sink    req_chan,
   kfm_rsp_if.source  rsp_chan
);
   import kfm_pkg::*;

   localparam int PW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LW = $clog2(PATTERN_MAX + 1);
   localparam int TW = $clog2(TEXT_MAX + 1);
   localparam int SW0 = (TW > LW) ? TW : LW;
   localparam int SW = (SW0 > POS_W) ? SW0 : POS_W;

   // memories: pattern bytes and failure links ({negative, index})
   logic [BYTE_W-1:0] pat_mem  [PATTERN_MAX];
   logic [PW:0]       fail_mem [PATTERN_MAX];

   state_type         state_ff, state_in;
   logic [LW-1:0]     len_ff, len_in;
   logic              loading_ff, loading_in;
   logic              bpi_neg_ff, bpi_neg_in;
   logic [PW-1:0]     bpi_ff, bpi_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [PW-1:0]     matched_ff, matched_in;
   logic [TW-1:0]     pos_ff, pos_in;
   logic              done_ff, done_in;
   logic [PW-1:0]     k_ff, k_in;
   logic [BYTE_W-1:0] cmp_ff, cmp_in;
   logic              text_mode_ff, text_mode_in;
   logic              last_ff, last_in;
   logic [PW-1:0]     wj_ff, wj_in;
   logic              res_found_ff, res_found_in;
   logic [POS_W-1:0]  res_pos_ff, res_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;

   logic [BYTE_W-1:0] pat_rd_ff;
   logic [PW:0]       fail_rd_ff;

   // memory port controls
   logic              rd_en;
   logic [PW-1:0]     rd_addr;
   logic              pw_en;
   logic [PW-1:0]     pw_addr;
   logic              fw_en;
   logic [PW-1:0]     fw_addr;
   logic [PW:0]       fw_data;

   // helpers
   logic              accept;
   logic [LW-1:0]     len_eff;
   logic              bpi_neg_eff;
   logic              hit;
   logic [LW-1:0]     fin;
   logic [SW-1:0]     start_pos;
   logic              emit;

   assign accept          = req_chan.valid && req_chan.ready;
   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.found  = rsp_found_ff;
   assign rsp_chan.match_position = rsp_pos_ff;

   assign len_eff     = loading_ff ? len_ff : '0;
   assign bpi_neg_eff = loading_ff ? bpi_neg_ff : 1'b1;
   assign hit         = (pat_rd_ff == cmp_ff);
   assign fin         = hit ? (LW'(k_ff) + LW'(1)) : '0;
   assign start_pos   = SW'(pos_ff) - SW'(len_ff);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      loading_in   = loading_ff;
      bpi_neg_in   = bpi_neg_ff;
      bpi_in       = bpi_ff;
      prev_in      = prev_ff;
      matched_in   = matched_ff;
      pos_in       = pos_ff;
      done_in      = done_ff;
      k_in         = k_ff;
      cmp_in       = cmp_ff;
      text_mode_in = text_mode_ff;
      last_in      = last_ff;
      wj_in        = wj_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      pw_en        = 1'b0;
      pw_addr      = len_eff[PW-1:0];
      fw_en        = 1'b0;
      fw_addr      = wj_ff;
      fw_data      = '0;
      emit         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_chan.last_flag;
               if (req_chan.command == CMD_PATTERN) begin
                  // pattern byte: store, build link, restart search
                  loading_in = !req_chan.last_flag;
                  matched_in = '0;
                  pos_in     = '0;
                  done_in    = 1'b0;
                  len_in     = len_eff;
                  bpi_neg_in = bpi_neg_eff;
                  if (len_eff < LW'(PATTERN_MAX)) begin
                     pw_en   = 1'b1;
                     prev_in = req_chan.byte_value;
                     len_in  = len_eff + LW'(1);
                     wj_in   = len_eff[PW-1:0];
                     if (len_eff == '0) begin
                        fw_en      = 1'b1;
                        fw_addr    = '0;
                        fw_data    = {1'b1, {PW{1'b0}}};
                        bpi_neg_in = 1'b1;
                     end else if (bpi_neg_eff) begin
                        fw_en      = 1'b1;
                        fw_addr    = len_eff[PW-1:0];
                        fw_data    = '0;
                        bpi_neg_in = 1'b0;
                        bpi_in     = '0;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = bpi_ff;
                        k_in         = bpi_ff;
                        cmp_in       = prev_ff;
                        text_mode_in = 1'b0;
                        state_in     = ST_CMP;
                     end
                  end
               end else begin
                  // text byte
                  loading_in = 1'b0;
                  if (!done_ff && (pos_ff < TW'(TEXT_MAX))) begin
                     pos_in = pos_ff + TW'(1);
                     if (len_ff == '0) begin
                        res_found_in = 1'b1;
                        res_pos_in   = '0;
                        emit         = 1'b1;
                        done_in      = 1'b1;
                        if (req_chan.last_flag) begin
                           matched_in = '0;
                           pos_in     = '0;
                           done_in    = 1'b0;
                        end
                        state_in = ST_EMIT;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = matched_ff;
                        k_in         = matched_ff;
                        cmp_in       = req_chan.byte_value;
                        text_mode_in = 1'b1;
                        state_in     = ST_CMP;
                     end
                  end else if (req_chan.last_flag) begin
                     if (!done_ff) begin
                        res_found_in = 1'b0;
                        res_pos_in   = '0;
                        state_in     = ST_EMIT;
                     end
                     matched_in = '0;
                     pos_in     = '0;
                     done_in    = 1'b0;
                  end
               end
            end
         end

         ST_CMP: begin
            if (!hit && !fail_rd_ff[PW]) begin
               // fall back along the failure link
               rd_en    = 1'b1;
               rd_addr  = fail_rd_ff[PW-1:0];
               k_in     = fail_rd_ff[PW-1:0];
            end else if (!text_mode_ff) begin
               // finish failure link of the new pattern byte
               fw_en      = 1'b1;
               fw_addr    = wj_ff;
               fw_data    = {1'b0, fin[PW-1:0]};
               bpi_neg_in = 1'b0;
               bpi_in     = fin[PW-1:0];
               state_in   = ST_IDLE;
            end else begin
               // finish text byte
               state_in = ST_IDLE;
               if (fin == len_ff) begin
                  res_found_in = 1'b1;
                  res_pos_in   = start_pos[POS_W-1:0];
                  emit         = 1'b1;
                  done_in      = 1'b1;
                  matched_in   = '0;
                  state_in     = ST_EMIT;
               end else begin
                  matched_in = fin[PW-1:0];
               end
               if (last_ff) begin
                  if (!emit) begin
                     res_found_in = 1'b0;
                     res_pos_in   = '0;
                     state_in     = ST_EMIT;
                  end
                  matched_in = '0;
                  pos_in     = '0;
                  done_in    = 1'b0;
               end
            end
         end

         ST_EMIT: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_pos_in   = res_pos_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         loading_ff   <= 1'b0;
         bpi_neg_ff   <= 1'b1;
         bpi_ff       <= '0;
         matched_ff   <= '0;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         loading_ff   <= loading_in;
         bpi_neg_ff   <= bpi_neg_in;
         bpi_ff       <= bpi_in;
         matched_ff   <= matched_in;
         pos_ff       <= pos_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_ff      <= prev_in;
      k_ff         <= k_in;
      cmp_ff       <= cmp_in;
      text_mode_ff <= text_mode_in;
      last_ff      <= last_in;
      wj_ff        <= wj_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   // pattern memory
   always_ff @(posedge clock) begin
      if (pw_en) begin
         pat_mem[pw_addr] <= req_chan.byte_value;
      end
      if (rd_en) begin
         pat_rd_ff <= pat_mem[rd_addr];
      end
   end

   // failure link memory
   always_ff @(posedge clock) begin
      if (fw_en) begin
         fail_mem[fw_addr] <= fw_data;
      end
      if (rd_en) begin
         fail_rd_ff <= fail_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* dv/kfm_match_checker.sv */
`timescale 1ns / 100ps
// checker for the kmp first match finder: search predictor and result compare

module kfm_match_checker #(
   parameter int PAT_CAP   = 128,
   parameter int POS_LIMIT = 65536
) (
   input  wire clock,
   input  wire reset,
   kfm_req_if  req_mon,
   kfm_rsp_if  rsp_mon,
   output int  mismatch_count,
   output int  waiting_count,
   output int  found_count,
   output int  missed_count
);
   import kfm_pkg::*;

   typedef struct {
      logic             found;
      logic [POS_W-1:0] position;
   } verdict_type;

   // predicted search outcomes, oldest first
   verdict_type match_verdicts[$];
   verdict_type oldest;

   // predictor copy of the pattern, its failure links and the search state
   logic [BYTE_W-1:0] pat_mem  [PAT_CAP];
   int                link_mem [PAT_CAP];
   int                pat_len;
   int                build_k;
   int                match_len;
   int                text_pos;
   bit                search_over;
   bit                load_open;

   int mismatches  = 0;
   int found_seen  = 0;
   int missed_seen = 0;

   // clear the search, keep the pattern
   function automatic void restart_search_state();
      match_len   = 0;
      text_pos    = 0;
      search_over = 1'b0;
   endfunction

   function automatic void reset_predictor();
      pat_len   = 0;
      build_k   = -1;
      load_open = 1'b0;
      restart_search_state();
      match_verdicts.delete();
   endfunction

   // store one pattern byte and extend the failure table
   function automatic void absorb_pattern_byte(logic [BYTE_W-1:0] b, logic last);
      int k;
      if (!load_open) begin
         pat_len   = 0;
         build_k   = -1;
         load_open = 1'b1;
      end
      if (pat_len < PAT_CAP) begin
         pat_mem[pat_len] = b;
         if (pat_len == 0) begin
            link_mem[0] = -1;
            build_k     = -1;
         end else begin
            k = build_k;
            while (k >= 0 && pat_mem[k] != pat_mem[pat_len-1])
               k = link_mem[k];
            k = k + 1;
            link_mem[pat_len] = k;
            build_k           = k;
         end
         pat_len = pat_len + 1;
      end
      if (last)
         load_open = 1'b0;
      restart_search_state();
   endfunction

   // advance the search by one text byte, queue any outcome
   function automatic void scan_text_byte(logic [BYTE_W-1:0] b, logic last);
      int               j;
      int               start;
      logic [POS_W-1:0] wrapped;
      verdict_type      v;
      load_open = 1'b0;
      if (!search_over && text_pos < POS_LIMIT) begin
         start    = text_pos;
         text_pos = text_pos + 1;
         if (pat_len == 0) begin
            v.found    = 1'b1;
            v.position = '0;
            match_verdicts.push_back(v);
            search_over = 1'b1;
         end else begin
            j = match_len;
            while (j >= 0 && pat_mem[j] != b)
               j = link_mem[j];
            j = j + 1;
            if (j == pat_len) begin
               wrapped    = POS_W'(start + 1 - pat_len);
               v.found    = 1'b1;
               v.position = wrapped;
               match_verdicts.push_back(v);
               search_over = 1'b1;
               j = 0;
            end
            match_len = j;
         end
      end
      if (last) begin
         if (!search_over) begin
            v.found    = 1'b0;
            v.position = '0;
            match_verdicts.push_back(v);
         end
         restart_search_state();
      end
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_predictor();
      end else begin
         // compare an accepted result with the oldest prediction
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (match_verdicts.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: found=%0b position=%0d",
                                         rsp_mon.found, rsp_mon.match_position));
            end else begin
               oldest = match_verdicts.pop_front();
               if (rsp_mon.found !== oldest.found)
                  report_mismatch($sformatf("found is %0b, expected %0b",
                                            rsp_mon.found, oldest.found));
               if (rsp_mon.match_position !== oldest.position)
                  report_mismatch($sformatf("match_position is %0d, expected %0d",
                                            rsp_mon.match_position, oldest.position));
               if (oldest.found)
                  found_seen++;
               else
                  missed_seen++;
            end
         end
         // predict from an accepted item
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.command == CMD_TEXT)
               scan_text_byte(req_mon.byte_value, req_mon.last_flag);
            else
               absorb_pattern_byte(req_mon.byte_value, req_mon.last_flag);
         end
      end
      mismatch_count <= mismatches;
      waiting_count  <= match_verdicts.size();
      found_count    <= found_seen;
      missed_count   <= missed_seen;
   end

endmodule

/* dv/kmp_first_match_finder_unit_test.sv */
`timescale 1ns / 100ps
// testbench top for the kmp first match finder: stimulus, idling and verdict

module kmp_first_match_finder_unit_test;
   import kfm_pkg::*;

   // small sizes so overflow and the position limit come up often
   localparam int PAT_CAP    = 16;
   localparam int POS_LIMIT  = 64;
   localparam int ITEM_GOAL  = 1050;
   localparam int DRAIN_WAIT = 4 * PAT_CAP + 20;
   localparam int STALL_LONG = 400;

   logic clock;
   logic reset;

   kfm_req_if req_chan ();
   kfm_rsp_if rsp_chan ();

   int mismatch_count;
   int waiting_count;
   int found_count;
   int missed_count;

   int items_sent     = 0;
   int loads_sent     = 0;
   int overflow_loads = 0;
   int limit_texts    = 0;
   bit long_stall_done = 1'b0;
   bit no_idle         = 1'b0;

   // byte alphabet of the current sequence
   int                alpha_mode;
   logic [BYTE_W-1:0] alphabet [3];

   kmp_first_match_finder_unit #(
      .PATTERN_MAX (PAT_CAP),
      .TEXT_MAX    (POS_LIMIT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   kfm_match_checker #(
      .PAT_CAP   (PAT_CAP),
      .POS_LIMIT (POS_LIMIT)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .waiting_count  (waiting_count),
      .found_count    (found_count),
      .missed_count   (missed_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #8_000_000;
      $display("timeout: block stopped making progress");
      $display("status: fail");
      $finish;
   end

   function automatic int pick_send_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_take_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      if (alpha_mode == 0)
         return alphabet[$urandom_range(0, 1)];
      if (alpha_mode == 1)
         return alphabet[$urandom_range(0, 2)];
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // offer one item and wait until it is taken
   task automatic send_item(logic cmd, logic [BYTE_W-1:0] b, logic last);
      int gap;
      gap = pick_send_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.byte_value <= b;
      req_chan.last_flag  <= last;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      items_sent++;
   endtask

   task automatic run_directed();
      // empty pattern after reset matches at position zero
      send_item(CMD_TEXT, 8'h00, 1'b1);
      // empty pattern again, the rest of that text is ignored
      send_item(CMD_TEXT, 8'hFF, 1'b0);
      send_item(CMD_TEXT, 8'h5A, 1'b1);
      // two byte pattern with the extreme byte values, match at one
      send_item(CMD_PATTERN, 8'hFF, 1'b0);
      send_item(CMD_PATTERN, 8'h00, 1'b1);
      send_item(CMD_TEXT, 8'h00, 1'b0);
      send_item(CMD_TEXT, 8'hFF, 1'b0);
      send_item(CMD_TEXT, 8'h00, 1'b0);
      send_item(CMD_TEXT, 8'hFF, 1'b1);
      // text ends without a match
      send_item(CMD_TEXT, 8'hFF, 1'b1);
      // open load closed by a text byte
      send_item(CMD_PATTERN, 8'hA5, 1'b0);
      send_item(CMD_TEXT, 8'hA5, 1'b1);
      // pattern byte in the middle of a text restarts the search
      send_item(CMD_PATTERN, 8'h3C, 1'b1);
      send_item(CMD_TEXT, 8'h11, 1'b0);
      send_item(CMD_PATTERN, 8'hC3, 1'b1);
      send_item(CMD_TEXT, 8'hC3, 1'b1);
      // repeated bytes make the search fall back along failure links
      send_item(CMD_PATTERN, 8'h0A, 1'b0);
      send_item(CMD_PATTERN, 8'h0A, 1'b0);
      send_item(CMD_PATTERN, 8'h0B, 1'b1);
      send_item(CMD_TEXT, 8'h0A, 1'b0);
      send_item(CMD_TEXT, 8'h0A, 1'b0);
      send_item(CMD_TEXT, 8'h0A, 1'b0);
      send_item(CMD_TEXT, 8'h0B, 1'b1);
   endtask

   // one pattern load followed by a few texts, some with the pattern planted
   task automatic run_sequence();
      logic [BYTE_W-1:0] pat [PAT_CAP+4];
      logic [BYTE_W-1:0] txt [POS_LIMIT+8];
      int i;
      int t;
      int roll;
      int plen;
      int eff_len;
      int n_texts;
      int tlen;
      int at;
      bit close_load;
      bit end_text;
      for (i = 0; i < 3; i++)
         alphabet[i] = BYTE_W'($urandom_range(0, 255));
      alpha_mode = $urandom_range(0, 2);
      no_idle    = ($urandom_range(0, 4) == 0);

      // pattern load, now and then past capacity or left open
      roll = $urandom_range(0, 99);
      if (roll < 70)
         plen = $urandom_range(1, 6);
      else if (roll < 90)
         plen = $urandom_range(7, PAT_CAP);
      else
         plen = $urandom_range(PAT_CAP + 1, PAT_CAP + 4);
      for (i = 0; i < plen; i++)
         pat[i] = pick_byte();
      close_load = ($urandom_range(0, 99) < 85);
      for (i = 0; i < plen; i++)
         send_item(CMD_PATTERN, pat[i], close_load && i == plen - 1);
      loads_sent++;
      if (plen > PAT_CAP)
         overflow_loads++;
      eff_len = (plen < PAT_CAP) ? plen : PAT_CAP;

      // texts, mostly short, a few running past the position limit
      n_texts = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
      for (t = 0; t < n_texts; t++) begin
         roll = $urandom_range(0, 99);
         if (roll < 82)
            tlen = $urandom_range(1, 24);
         else if (roll < 92)
            tlen = $urandom_range(25, POS_LIMIT - 1);
         else
            tlen = $urandom_range(POS_LIMIT - 4, POS_LIMIT + 8);
         if (tlen > POS_LIMIT)
            limit_texts++;
         for (i = 0; i < tlen; i++)
            txt[i] = pick_byte();
         if (tlen >= eff_len && $urandom_range(0, 1) == 1) begin
            at = $urandom_range(0, tlen - eff_len);
            for (i = 0; i < eff_len; i++)
               txt[at + i] = pat[i];
         end
         end_text = ($urandom_range(0, 99) < 92);
         for (i = 0; i < tlen; i++) begin
            if ($urandom_range(0, 99) < 3)
               send_item(CMD_PATTERN, BYTE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            send_item(CMD_TEXT, txt[i], end_text && i == tlen - 1);
         end
      end
   endtask

   // result side: random hold-offs, one long one while items keep coming
   initial begin
      int hold;
      int open_len;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!long_stall_done && items_sent >= 300) begin
            hold            = STALL_LONG;
            long_stall_done = 1'b1;
         end else begin
            hold = pick_take_gap();
         end
         open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150)
                                                : $urandom_range(1, 8);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat (open_len) @(posedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.command    <= CMD_PATTERN;
      req_chan.byte_value <= '0;
      req_chan.last_flag  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      while (items_sent < ITEM_GOAL)
         run_sequence();
      req_chan.valid <= 1'b0;

      // drain outstanding results, then watch for strays
      @(posedge clock);
      while (waiting_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d items in %0d pattern loads (%0d past capacity), %0d long texts",
               items_sent, loads_sent, overflow_loads, limit_texts);
      $display("checked %0d match results and %0d not-found results",
               found_count, missed_count);
      if (mismatch_count == 0 && waiting_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
src/kfm_pkg.sv
src/kfm_if.sv
src/kmp_first_match_finder_unit.sv
dv/kfm_match_checker.sv
dv/kmp_first_match_finder_unit_test.sv
